### design/lsi_pkg.sv
// ----------------------------------------------------------------------------
// lsi_pkg
// Types, widths and helper functions shared by the line/sphere intersect core.
// ----------------------------------------------------------------------------
package lsi_pkg;

  // fixed-point formats: positions Q16.16, direction Q2.30
  localparam int POS_W    = 32;
  localparam int DIR_W    = 32;
  localparam int RAD_W    = 31;
  localparam int DIR_FRAC = 30;

  // internal widths, sized for the worst-case magnitudes
  localparam int D_W    = POS_W + 1;        // center minus base point
  localparam int PDU_W  = D_W + DIR_W;      // d * u product
  localparam int TERM_W = PDU_W - DIR_FRAC; // one term of s
  localparam int SQ_W   = 2 * D_W - 1;      // d * d, non-negative
  localparam int S_W    = TERM_W + 2;       // s = sum of three terms
  localparam int DD_W   = SQ_W + 2;         // sum of three squares
  localparam int SS_W   = 2 * S_W - 4;      // s * s, non-negative
  localparam int R2_W   = 2 * RAD_W;        // r * r
  localparam int RADX_W = R2_W + 2;         // radicand padded to an even width
  localparam int Q_W    = RADX_W / 2;       // square root result
  localparam int REM_W  = Q_W + 3;          // square root remainder
  localparam int SQRT_PER_STG = 2;          // root bits resolved per stage
  localparam int SQRT_STG = Q_W / SQRT_PER_STG;
  localparam int T_W    = S_W + 1;          // s -/+ q
  localparam int PUT_W  = DIR_W + T_W;      // u * t product
  localparam int OFF_W  = PUT_W - DIR_FRAC; // offset along the line
  localparam int V_W    = OFF_W + 1;        // base point plus offset

  localparam logic signed [DIR_W-1:0] DIR_ONE = 32'sh4000_0000;
  localparam logic signed [DIR_W-1:0] DIR_NEG = -32'sh4000_0000;
  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [DIR_W-1:0] dir_t;

  // one request: index 0 is x, 1 is y, 2 is z
  typedef struct packed {
    pos_t [2:0]       p;
    dir_t [2:0]       u;
    pos_t [2:0]       c;
    logic [RAD_W-1:0] r;
  } req_t;

  // front end result, carried through the root pipeline
  typedef struct packed {
    logic                  hit;
    logic signed [S_W-1:0] s;
    logic [R2_W-1:0]       rad;
    pos_t [2:0]            p;
    dir_t [2:0]            u;
  } front_t;

  typedef struct packed {
    front_t         f;
    logic [Q_W-1:0] q;
  } sq_t;

  typedef struct packed {
    logic       hit;
    logic       fwd;
    pos_t [2:0] near;
    pos_t [2:0] far;
  } rsp_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   root;
  } sqs_t;

  // one digit of the restoring square root
  function automatic sqs_t sqrt_step(sqs_t st, logic [1:0] pair);
    sqs_t             res;
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    cur   = {st.rem[REM_W-3:0], pair};
    trial = REM_W'({st.root, 2'b01});
    if (cur >= trial) begin
      res.rem  = cur - trial;
      res.root = {st.root[Q_W-2:0], 1'b1};
    end else begin
      res.rem  = cur;
      res.root = {st.root[Q_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

### design/lsi_req_if.sv
// ----------------------------------------------------------------------------
// lsi_req_if
// Request channel: one line and one sphere per request.
// ----------------------------------------------------------------------------
interface lsi_req_if;
  import lsi_pkg::*;

  logic               valid;
  logic               ready;
  logic signed [POS_W-1:0] line_px;
  logic signed [POS_W-1:0] line_py;
  logic signed [POS_W-1:0] line_pz;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;
  logic signed [POS_W-1:0] sphere_cx;
  logic signed [POS_W-1:0] sphere_cy;
  logic signed [POS_W-1:0] sphere_cz;
  logic [RAD_W-1:0]        sphere_radius;

  modport source (
    output valid, line_px, line_py, line_pz, dir_x, dir_y, dir_z,
    output sphere_cx, sphere_cy, sphere_cz, sphere_radius,
    input  ready
  );
  modport sink (
    input  valid, line_px, line_py, line_pz, dir_x, dir_y, dir_z,
    input  sphere_cx, sphere_cy, sphere_cz, sphere_radius,
    output ready
  );
endinterface

### design/lsi_rsp_if.sv
// ----------------------------------------------------------------------------
// lsi_rsp_if
// Result channel: hit flags and the near and far points.
// ----------------------------------------------------------------------------
interface lsi_rsp_if;
  import lsi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic                    forward_hit;
  logic signed [POS_W-1:0] near_x;
  logic signed [POS_W-1:0] near_y;
  logic signed [POS_W-1:0] near_z;
  logic signed [POS_W-1:0] far_x;
  logic signed [POS_W-1:0] far_y;
  logic signed [POS_W-1:0] far_z;

  modport source (
    output valid, hit, forward_hit, near_x, near_y, near_z, far_x, far_y, far_z,
    input  ready
  );
  modport sink (
    input  valid, hit, forward_hit, near_x, near_y, near_z, far_x, far_y, far_z,
    output ready
  );
endinterface

### design/lsi_front.sv
// ----------------------------------------------------------------------------
// lsi_front
// Five stages: offset, products, sums, s squared, hit test and radicand.
// ----------------------------------------------------------------------------
module lsi_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  lsi_pkg::req_t   in_req,
  output logic            out_vld,
  output lsi_pkg::front_t out_data
);
  import lsi_pkg::*;

  logic vld1, vld2, vld3, vld4;

  // stage 1
  pos_t [2:0]            p1;
  dir_t [2:0]            u1;
  logic signed [D_W-1:0] d1 [3];
  logic [RAD_W-1:0]      r1;
  dir_t [2:0]            u_next;
  logic signed [D_W-1:0] d_next [3];

  // stage 2
  pos_t [2:0]               p2;
  dir_t [2:0]               u2;
  logic signed [TERM_W-1:0] term2 [3];
  logic [SQ_W-1:0]          sq2 [3];
  logic [R2_W-1:0]          rr2;
  logic signed [TERM_W-1:0] term_next [3];
  logic [SQ_W-1:0]          sq_next [3];

  // stage 3
  pos_t [2:0]            p3;
  dir_t [2:0]            u3;
  logic signed [S_W-1:0] s3;
  logic [DD_W-1:0]       dd3;
  logic [R2_W-1:0]       rr3;

  // stage 4
  pos_t [2:0]            p4;
  dir_t [2:0]            u4;
  logic signed [S_W-1:0] s4;
  logic [DD_W-1:0]       dd4;
  logic [SS_W-1:0]       ss4;
  logic [R2_W-1:0]       rr4;
  logic signed [2*S_W-1:0] ss_prod;

  // stage 5
  logic [SS_W-1:0] dd_ext;
  logic [SS_W-1:0] m_val;
  logic            hit_next;
  logic [R2_W-1:0] rad_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if ($signed(in_req.u[i]) > DIR_ONE) begin
        u_next[i] = DIR_ONE;
      end else if ($signed(in_req.u[i]) < DIR_NEG) begin
        u_next[i] = DIR_NEG;
      end else begin
        u_next[i] = in_req.u[i];
      end
      d_next[i] = D_W'($signed(in_req.c[i])) - D_W'($signed(in_req.p[i]));
    end
  end

  always_comb begin
    logic signed [PDU_W-1:0] pdu;
    logic signed [2*D_W-1:0] pdd;
    pdu = '0;
    pdd = '0;
    for (int i = 0; i < 3; i++) begin
      pdu          = d1[i] * $signed(u1[i]);
      pdd          = d1[i] * d1[i];
      term_next[i] = TERM_W'(pdu >>> DIR_FRAC);
      sq_next[i]   = pdd[SQ_W-1:0];
    end
  end

  assign ss_prod = s3 * s3;

  always_comb begin
    dd_ext = SS_W'(dd4);
    if (dd_ext > ss4) begin
      m_val = dd_ext - ss4;
    end else begin
      m_val = '0;
    end
    hit_next = (m_val <= SS_W'(rr4));
    rad_next = hit_next ? (rr4 - m_val[R2_W-1:0]) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      vld4    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      vld3    <= vld2;
      vld4    <= vld3;
      out_vld <= vld4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= in_req.p;
      u1 <= u_next;
      d1 <= d_next;
      r1 <= in_req.r;

      p2    <= p1;
      u2    <= u1;
      term2 <= term_next;
      sq2   <= sq_next;
      rr2   <= R2_W'(r1) * R2_W'(r1);

      p3  <= p2;
      u3  <= u2;
      s3  <= S_W'(term2[0]) + S_W'(term2[1]) + S_W'(term2[2]);
      dd3 <= DD_W'(sq2[0]) + DD_W'(sq2[1]) + DD_W'(sq2[2]);
      rr3 <= rr2;

      p4  <= p3;
      u4  <= u3;
      s4  <= s3;
      dd4 <= dd3;
      ss4 <= ss_prod[SS_W-1:0];
      rr4 <= rr3;

      out_data.hit <= hit_next;
      out_data.s   <= s4;
      out_data.rad <= rad_next;
      out_data.p   <= p4;
      out_data.u   <= u4;
    end
  end

endmodule

### design/lsi_sqrt.sv
// ----------------------------------------------------------------------------
// lsi_sqrt
// Pipelined restoring square root, two root bits per stage.
// ----------------------------------------------------------------------------
module lsi_sqrt (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  lsi_pkg::front_t in_data,
  output logic            out_vld,
  output lsi_pkg::sq_t    out_data
);
  import lsi_pkg::*;

  logic              vld  [SQRT_STG+1];
  sqs_t              st   [SQRT_STG+1];
  logic [RADX_W-1:0] x    [SQRT_STG+1];
  front_t            side [SQRT_STG+1];

  assign vld[0]  = in_vld;
  assign st[0]   = '0;
  assign x[0]    = RADX_W'(in_data.rad);
  assign side[0] = in_data;

  for (genvar k = 0; k < SQRT_STG; k++) begin : g_stage
    sqs_t st_next;

    always_comb begin
      sqs_t tmp;
      tmp = st[k];
      for (int j = 0; j < SQRT_PER_STG; j++) begin
        tmp = sqrt_step(tmp, x[k][RADX_W-1-2*j -: 2]);
      end
      st_next = tmp;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1]   <= st_next;
        x[k+1]    <= x[k] << (2 * SQRT_PER_STG);
        side[k+1] <= side[k];
      end
    end
  end

  assign out_vld    = vld[SQRT_STG];
  assign out_data.f = side[SQRT_STG];
  assign out_data.q = st[SQRT_STG].root;

endmodule

### design/lsi_back.sv
// ----------------------------------------------------------------------------
// lsi_back
// Three stages: line parameters, offsets along the line, saturated points.
// ----------------------------------------------------------------------------
module lsi_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_vld,
  input  lsi_pkg::sq_t  in_data,
  output logic          out_vld,
  output lsi_pkg::rsp_t out_data
);
  import lsi_pkg::*;

  logic vld1, vld2;

  // stage 1
  logic                  hit1, fwd1;
  pos_t [2:0]            p1;
  dir_t [2:0]            u1;
  logic signed [T_W-1:0] t1_near, t1_far;
  logic signed [T_W-1:0] near_t_next, far_t_next;

  // stage 2
  logic                    hit2, fwd2;
  pos_t [2:0]              p2;
  logic signed [OFF_W-1:0] off_near [3];
  logic signed [OFF_W-1:0] off_far  [3];
  logic signed [OFF_W-1:0] off_near_next [3];
  logic signed [OFF_W-1:0] off_far_next  [3];

  // stage 3
  rsp_t rsp_next;

  assign near_t_next = T_W'(in_data.f.s) - T_W'($signed({1'b0, in_data.q}));
  assign far_t_next  = T_W'(in_data.f.s) + T_W'($signed({1'b0, in_data.q}));

  always_comb begin
    logic signed [PUT_W-1:0] pn;
    logic signed [PUT_W-1:0] pf;
    pn = '0;
    pf = '0;
    for (int i = 0; i < 3; i++) begin
      pn               = $signed(u1[i]) * t1_near;
      pf               = $signed(u1[i]) * t1_far;
      off_near_next[i] = OFF_W'(pn >>> DIR_FRAC);
      off_far_next[i]  = OFF_W'(pf >>> DIR_FRAC);
    end
  end

  function automatic pos_t sat_pos(logic signed [V_W-1:0] v);
    pos_t res;
    if ((&v[V_W-1:POS_W-1]) || !(|v[V_W-1:POS_W-1])) begin
      res = v[POS_W-1:0];
    end else if (v[V_W-1]) begin
      res = POS_MIN;
    end else begin
      res = POS_MAX;
    end
    return res;
  endfunction

  always_comb begin
    rsp_next.hit = hit2;
    rsp_next.fwd = fwd2;
    for (int i = 0; i < 3; i++) begin
      if (hit2) begin
        rsp_next.near[i] = sat_pos(V_W'($signed(p2[i])) + V_W'(off_near[i]));
        rsp_next.far[i]  = sat_pos(V_W'($signed(p2[i])) + V_W'(off_far[i]));
      end else begin
        rsp_next.near[i] = '0;
        rsp_next.far[i]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit1    <= in_data.f.hit;
      fwd1    <= in_data.f.hit && ((near_t_next > 0) || (far_t_next > 0));
      p1      <= in_data.f.p;
      u1      <= in_data.f.u;
      t1_near <= near_t_next;
      t1_far  <= far_t_next;

      hit2     <= hit1;
      fwd2     <= fwd1;
      p2       <= p1;
      off_near <= off_near_next;
      off_far  <= off_far_next;

      out_data <= rsp_next;
    end
  end

endmodule

### design/line_sphere_intersect_core.sv
// ----------------------------------------------------------------------------
// line_sphere_intersect_core
// Stages: 5 front, 16 root and 3 back; the last is the output register.
// Throughput: one request per cycle; the pipeline advances whenever the
//   output register is empty or its result is taken in the same cycle.
// Reset: synchronous rst clears every stage valid bit; data is not reset.
// ----------------------------------------------------------------------------
module line_sphere_intersect_core (
  input logic      clk,
  input logic      rst,
  lsi_req_if.sink  req,
  lsi_rsp_if.source rsp
);
  import lsi_pkg::*;

  // global advance: the output register is free or drains this cycle
  logic   en;
  req_t   req_data;
  logic   front_vld;
  front_t front_data;
  logic   sq_vld;
  sq_t    sq_data;
  logic   out_vld;
  rsp_t   out_data;

  assign en        = !out_vld || rsp.ready;
  assign req.ready = en;

  // pack the request into index-ordered vectors
  always_comb begin
    req_data.p[0] = req.line_px;
    req_data.p[1] = req.line_py;
    req_data.p[2] = req.line_pz;
    req_data.u[0] = req.dir_x;
    req_data.u[1] = req.dir_y;
    req_data.u[2] = req.dir_z;
    req_data.c[0] = req.sphere_cx;
    req_data.c[1] = req.sphere_cy;
    req_data.c[2] = req.sphere_cz;
    req_data.r    = req.sphere_radius;
  end

  // offset, projection, squared distance and the hit test
  lsi_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (req.valid),
    .in_req   (req_data),
    .out_vld  (front_vld),
    .out_data (front_data)
  );

  // half chord length q = floor(sqrt(r*r - m))
  lsi_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (front_vld),
    .in_data  (front_data),
    .out_vld  (sq_vld),
    .out_data (sq_data)
  );

  // near and far points, saturated, zero on a miss
  lsi_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (sq_vld),
    .in_data  (sq_data),
    .out_vld  (out_vld),
    .out_data (out_data)
  );

  assign rsp.valid       = out_vld;
  assign rsp.hit         = out_data.hit;
  assign rsp.forward_hit = out_data.fwd;
  assign rsp.near_x      = out_data.near[0];
  assign rsp.near_y      = out_data.near[1];
  assign rsp.near_z      = out_data.near[2];
  assign rsp.far_x       = out_data.far[0];
  assign rsp.far_y       = out_data.far[1];
  assign rsp.far_z       = out_data.far[2];

  // a miss carries all-zero points
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.hit |-> (rsp.near_x == 0) && (rsp.near_y == 0) &&
      (rsp.near_z == 0) && (rsp.far_x == 0) && (rsp.far_y == 0) && (rsp.far_z == 0))
    else $error("miss result with nonzero point");

  // forward flag only on a hit
  a_fwd_hit: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.forward_hit |-> rsp.hit)
    else $error("forward flag without hit");

  // an empty output register never blocks requests
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("request stalled with empty output");

  // a result held under stall keeps its request blocked
  a_stall_block: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !req.ready)
    else $error("request accepted while pipeline stalled");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_sphere_intersect_core. A table of hand-made
// requests runs first, followed by random lines and spheres. Each accepted
// request is predicted or typed by hand, and each result is compared with the
// oldest prediction. Both handshake sides are throttled in phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import lsi_pkg::*;

  localparam int N_RANDOM   = 1350;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;   // settle time after the last result
  localparam int LONG_HOLD  = 300;    // long receiver stall, in cycles
  localparam logic signed [31:0] ONE_POS = 32'sh0001_0000;

  typedef struct {
    req_t rq;
    bit   known;   // expected result typed in by hand
    rsp_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lsi_req_if req ();
  lsi_rsp_if rsp ();

  line_sphere_intersect_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  always #10 clk = ~clk;

  // pending predictions, oldest first
  rsp_t      expected_hits[$];
  stim_row_t stim_table[$];
  int        n_errors   = 0;
  int        n_checked  = 0;   // results taken from the block so far
  int        cycle_cnt  = 0;
  int        sender_idle = 36;
  int        recv_idle   = 80;
  bit        hold_request = 1'b0;
  bit        stim_done    = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // integer square root, bit by bit
  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b   = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // base point plus direction times t, clipped to the 32 bit range
  function automatic pos_t point_on_line(logic signed [127:0] p, logic signed [127:0] u,
                                         logic signed [127:0] t);
    logic signed [127:0] v;
    v = p + ((u * t) >>> DIR_FRAC);
    if (v > 128'sd2147483647) v = 128'sd2147483647;
    if (v < -128'sd2147483648) v = -128'sd2147483648;
    return pos_t'(v[31:0]);
  endfunction

  function automatic rsp_t predict_intersection(req_t rq);
    logic signed [127:0] p[3];
    logic signed [127:0] u[3];
    logic signed [127:0] d[3];
    logic signed [127:0] s;
    logic signed [127:0] dd;
    logic signed [127:0] ss;
    logic signed [127:0] m;
    logic signed [127:0] r2;
    logic signed [127:0] q;
    logic signed [127:0] t1;
    logic signed [127:0] t2;
    rsp_t res;
    res = '0;
    s   = '0;
    dd  = '0;
    for (int i = 0; i < 3; i++) begin
      p[i] = rq.p[i];
      u[i] = rq.u[i];
      // direction components are clipped to plus or minus one
      if (u[i] > 128'sd1073741824) u[i] = 128'sd1073741824;
      if (u[i] < -128'sd1073741824) u[i] = -128'sd1073741824;
      d[i] = 128'(rq.c[i]) - p[i];
      s  = s + ((d[i] * u[i]) >>> DIR_FRAC);
      dd = dd + d[i] * d[i];
    end
    ss = s * s;
    // a non-unit direction can push s*s past d.d: distance taken as zero
    m  = (ss < dd) ? dd - ss : 128'sd0;
    r2 = $signed({97'd0, rq.r}) * $signed({97'd0, rq.r});
    if (m > r2) return res;
    q  = $signed({64'd0, int_sqrt(64'(r2 - m))});
    t1 = s - q;
    t2 = s + q;
    res.hit = 1'b1;
    res.fwd = (t1 > 0) || (t2 > 0);
    for (int i = 0; i < 3; i++) begin
      res.near[i] = point_on_line(p[i], u[i], t1);
      res.far[i]  = point_on_line(p[i], u[i], t2);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic req_t make_req(pos_t px, pos_t py, pos_t pz, dir_t ux, dir_t uy,
                                    dir_t uz, pos_t cx, pos_t cy, pos_t cz,
                                    logic [RAD_W-1:0] r);
    req_t rq;
    rq.p = {pz, py, px};
    rq.u = {uz, uy, ux};
    rq.c = {cz, cy, cx};
    rq.r = r;
    return rq;
  endfunction

  function automatic rsp_t make_rsp(bit h, bit f, pos_t nx, pos_t fx);
    rsp_t r;
    r = '0;
    r.hit = h;
    r.fwd = f;
    r.near[0] = nx;
    r.far[0]  = fx;
    return r;
  endfunction

  function automatic void add_row(req_t rq, bit known, rsp_t want);
    stim_row_t row;
    row.rq    = rq;
    row.known = known;
    row.want  = want;
    stim_table.push_back(row);
  endfunction

  function automatic dir_t rand_dir();
    case ($urandom_range(0, 3))
      0: return ($urandom_range(0, 1) != 0) ? DIR_ONE : DIR_NEG;
      1: return dir_t'($urandom_range(0, 2 * 1073741824) - 1073741824);
      2: return dir_t'(0);
      default: return dir_t'($urandom);
    endcase
  endfunction

  // mostly nearby spheres, so hits are common; the rest is raw noise
  function automatic req_t rand_req();
    req_t rq;
    if ($urandom_range(0, 99) < 20) begin
      for (int i = 0; i < 3; i++) begin
        rq.p[i] = pos_t'($urandom);
        rq.u[i] = dir_t'($urandom);
        rq.c[i] = pos_t'($urandom);
      end
      rq.r = RAD_W'($urandom);
    end else begin
      int axis;
      axis = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
        rq.p[i] = pos_t'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        rq.c[i] = rq.p[i] + pos_t'($signed($urandom_range(0, 1 << 23)) - (1 << 22));
        rq.u[i] = ($urandom_range(0, 1) != 0) ? rand_dir() :
                  ((i == axis) ? DIR_ONE : dir_t'(0));
      end
      rq.r = RAD_W'($urandom_range(0, 1 << 23));
    end
    return rq;
  endfunction

  initial begin
    rsp_t none;
    none = '0;
    // clean miss: sphere far off the x axis
    add_row(make_req(0, 0, 0, DIR_ONE, 0, 0, 0, 100 * ONE_POS, 0, ONE_POS), 1, none);
    // straight hit ahead along x
    add_row(make_req(0, 0, 0, DIR_ONE, 0, 0, 10 * ONE_POS, 0, 0, 2 * ONE_POS), 1,
            make_rsp(1, 1, 8 * ONE_POS, 12 * ONE_POS));
    // touching counts as a hit, both points coincide
    add_row(make_req(0, 0, 0, DIR_ONE, 0, 0, 5 * ONE_POS, 3 * ONE_POS, 0, 3 * ONE_POS), 1,
            make_rsp(1, 1, 5 * ONE_POS, 5 * ONE_POS));
    // sphere behind the base point: hit, not forward
    add_row(make_req(0, 0, 0, DIR_ONE, 0, 0, -10 * ONE_POS, 0, 0, 2 * ONE_POS), 1,
            make_rsp(1, 0, -12 * ONE_POS, -8 * ONE_POS));
    // base point inside the sphere
    add_row(make_req(0, 0, 0, DIR_ONE, 0, 0, 0, 0, 0, 4 * ONE_POS), 1,
            make_rsp(1, 1, -4 * ONE_POS, 4 * ONE_POS));
    // everything zero: degenerate hit at the origin
    add_row(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, make_rsp(1, 0, 0, 0));
    // field extremes
    add_row(make_req(POS_MAX, POS_MAX, POS_MAX, DIR_NEG, 0, 0, POS_MIN, POS_MIN, POS_MIN,
                     {RAD_W{1'b1}}), 0, none);
    add_row(make_req(POS_MIN, POS_MIN, POS_MIN, 0, DIR_ONE, 0, POS_MAX, POS_MAX, POS_MAX,
                     0), 0, none);
    add_row(make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, {RAD_W{1'b1}}), 0, none);
    // direction out of range gets clipped
    add_row(make_req(0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 0, 3 * ONE_POS,
                     -2 * ONE_POS, 0, 5 * ONE_POS), 0, none);
    // non-unit direction
    add_row(make_req(0, 0, 0, DIR_ONE, DIR_ONE, DIR_ONE, ONE_POS, 2 * ONE_POS,
                     3 * ONE_POS, 0), 0, none);
    // far point runs off the top of the range
    add_row(make_req(32'sh7fff_0000, 0, 0, DIR_ONE, 0, 0, 32'sh7fff_0000, 0, 0,
                     {RAD_W{1'b1}}), 0, none);
    add_row(make_req(32'sh8000_0000, 0, 0, DIR_NEG, DIR_ONE, DIR_NEG, 32'sh8000_0000,
                     POS_MAX, POS_MIN, 31'h4000_0000), 0, none);
  end

  // ---------------------------------------------------------------------------
  // request driver: one nonblocking update of valid per edge
  // ---------------------------------------------------------------------------
  initial begin
    int   sent;
    int   total;
    req_t rq;
    req.valid = 1'b0;
    {req.line_px, req.line_py, req.line_pz} = '0;
    {req.dir_x, req.dir_y, req.dir_z} = '0;
    {req.sphere_cx, req.sphere_cy, req.sphere_cz} = '0;
    req.sphere_radius = '0;
    sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    total = stim_table.size() + N_RANDOM;
    while (sent < total) begin
      @(posedge clk);
      if (req.valid && !req.ready) continue;   // current request still pending
      // idling phases: receiver lazy first, then sender lazy, then full rate
      if (sent == total / 3) begin
        sender_idle = 80;
        recv_idle   = 36;
      end else if (sent == 2 * total / 3) begin
        sender_idle = 0;
        recv_idle   = 0;
        hold_request = 1'b1;   // receiver goes quiet while requests keep coming
      end
      if (sent == total / 2 && n_checked != sent) begin
        // pause until every sent request has come back
        req.valid <= 1'b0;
        continue;
      end
      if ($urandom_range(0, 99) < sender_idle) begin
        req.valid <= 1'b0;
        continue;
      end
      rq = (sent < stim_table.size()) ? stim_table[sent].rq : rand_req();
      req.line_px <= rq.p[0];
      req.line_py <= rq.p[1];
      req.line_pz <= rq.p[2];
      req.dir_x   <= rq.u[0];
      req.dir_y   <= rq.u[1];
      req.dir_z   <= rq.u[2];
      req.sphere_cx <= rq.c[0];
      req.sphere_cy <= rq.c[1];
      req.sphere_cz <= rq.c[2];
      req.sphere_radius <= rq.r;
      req.valid <= 1'b1;
      sent++;
    end
    // let the last request go through
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // accepted requests are predicted here; table rows may carry a typed result
  int accepted = 0;
  always @(posedge clk) begin
    req_t rq;
    if (!rst && req.valid && req.ready) begin
      rq = make_req(req.line_px, req.line_py, req.line_pz, req.dir_x, req.dir_y,
                    req.dir_z, req.sphere_cx, req.sphere_cy, req.sphere_cz,
                    req.sphere_radius);
      if (accepted < stim_table.size() && stim_table[accepted].known)
        expected_hits.push_back(stim_table[accepted].want);
      else
        expected_hits.push_back(predict_intersection(rq));
      accepted++;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: random stalls plus one long hold
  // ---------------------------------------------------------------------------
  initial rsp.ready = 1'b0;

  int  hold_cnt  = 0;
  bit  hold_used = 1'b0;
  always @(posedge clk) begin
    if (hold_request && !hold_used) begin
      if (hold_cnt < LONG_HOLD) begin
        hold_cnt++;
        rsp.ready <= 1'b0;
      end else begin
        hold_used = 1'b1;
        rsp.ready <= 1'b1;
      end
    end else begin
      rsp.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      n_checked++;
      got.hit = rsp.hit;
      got.fwd = rsp.forward_hit;
      got.near = {rsp.near_z, rsp.near_y, rsp.near_x};
      got.far  = {rsp.far_z, rsp.far_y, rsp.far_x};
      if (expected_hits.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result: %p", got);
      end else begin
        want = expected_hits.pop_front();
        if (got.hit !== want.hit || got.fwd !== want.fwd || got.near !== want.near ||
            got.far !== want.far) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // end of run and watchdog
  // ---------------------------------------------------------------------------
  initial begin
    wait (stim_done);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && expected_hits.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
